[rtl/wtm_pkg.sv]
// wtm_pkg: types and constants shared by the windowed throughput meter
// no dependencies; imported by every module of the block
`default_nettype none

package wtm_pkg;

	localparam int WIN_MS_W = 20;
	localparam int WIN_NS_W = 40;
	localparam int NOW_W    = 63;
	localparam int BYTES_W  = 32;
	localparam int BPS_W    = 40;
	localparam int FPS_W    = 32;

	localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
	localparam logic [19:0] NS_PER_MS  = 20'd1000000;
	localparam logic [WIN_NS_W-1:0] WIN_RESET_NS = 40'd1000000000;

	localparam logic [1:0] FUNC_RECORD = 2'd0;
	localparam logic [1:0] FUNC_QUERY  = 2'd1;
	localparam logic [1:0] FUNC_CLEAR  = 2'd2;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = 2;
	localparam int QCNT_W      = 3;

	typedef struct packed {
		logic [1:0]         func;
		logic [BYTES_W-1:0] byte_count_in;
		logic [NOW_W-1:0]   now_ns;
	} in_item_t;

	typedef struct packed {
		logic [BPS_W-1:0] bytes_per_sec;
		logic [FPS_W-1:0] frames_per_sec;
		logic             from_last_window;
	} out_item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

	typedef struct packed {
		logic start;
		logic wide;
	} div_ctl_t;

endpackage

`default_nettype wire

[rtl/wtm_front.sv]
// wtm_front: input side, accepts words and drops unused function codes
// depends on wtm_pkg; feeds wtm_queue
`default_nettype none

module wtm_front
	import wtm_pkg::*;
(
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_data,
	input  wire q_stat_t  q_stat,
	output logic          push,
	output in_item_t      push_data
);

	logic known;

	always_comb begin
		case (in_data.func)
			FUNC_RECORD, FUNC_QUERY, FUNC_CLEAR: known = 1'b1;
			default: known = 1'b0;
		endcase
	end

	assign in_ready  = !q_stat.full;
	assign push      = in_valid && in_ready && known;
	assign push_data = in_data;

endmodule

`default_nettype wire

[rtl/wtm_queue.sv]
// wtm_queue: short command queue between the front and the back
// depends on wtm_pkg
`default_nettype none

module wtm_queue
	import wtm_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     push,
	input  wire in_item_t push_data,
	input  wire logic     pop,
	output in_item_t      pop_data,
	output q_stat_t       q_stat
);

	in_item_t          entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QCNT_W-1:0] cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	assign pop_data     = entry_q[rd_q];
	assign q_stat.full  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign q_stat.empty = (cnt_q == '0);

endmodule

`default_nettype wire

[rtl/wtm_div.sv]
// wtm_div: scaled divider, floor(count * 1e9 / divisor) with saturation
// depends on wtm_pkg; multiply in 32-bit chunks, then one quotient bit a cycle
`default_nettype none

module wtm_div
	import wtm_pkg::*;
#(
	parameter int CNT_BITS = 48
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire div_ctl_t            ctl,
	input  wire logic [CNT_BITS-1:0] count,
	input  wire logic [62:0]         divisor,
	output logic                     done,
	output logic [BPS_W-1:0]         quot
);

	localparam int NCH  = (CNT_BITS + 31) / 32;
	localparam int CPW  = NCH * 32;
	localparam int PW   = CNT_BITS + 30;
	localparam int XW   = (PW > 64) ? PW : 64;
	localparam int MC_W = $clog2(NCH + 1);

	localparam logic [2:0] D_IDLE = 3'd0;
	localparam logic [2:0] D_MUL  = 3'd1;
	localparam logic [2:0] D_CHK  = 3'd2;
	localparam logic [2:0] D_DIV  = 3'd3;
	localparam logic [2:0] D_DONE = 3'd4;

	logic [2:0]       st_q;
	logic             wide_q;
	logic [CPW-1:0]   cnt_sh_q;
	logic [PW-1:0]    acc_q;
	logic [62:0]      d_q;
	logic [62:0]      rem_q;
	logic [BPS_W-1:0] sh_q;
	logic [5:0]       n_q;
	logic [MC_W-1:0]  mc_q;

	logic [31:0]    chunk;
	logic [61:0]    prod;
	logic [XW-1:0]  hi;
	logic           over;
	logic [63:0]    trial;
	logic [63:0]    diff;
	logic           ge;

	always_comb begin
		chunk = cnt_sh_q[CPW-1 -: 32];
		prod  = 62'(chunk) * 62'(NS_PER_SEC);
		hi    = wide_q ? (XW'(acc_q) >> BPS_W) : (XW'(acc_q) >> FPS_W);
		over  = hi >= XW'(d_q);
		trial = {rem_q, sh_q[BPS_W-1]};
		diff  = trial - {1'b0, d_q};
		ge    = trial >= {1'b0, d_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= D_IDLE;
		end else begin
			case (st_q)
				D_IDLE: begin
					if (ctl.start) begin
						st_q <= D_MUL;
					end
				end
				D_MUL: begin
					if (mc_q == MC_W'(1)) begin
						st_q <= D_CHK;
					end
				end
				D_CHK: begin
					st_q <= over ? D_DONE : D_DIV;
				end
				D_DIV: begin
					if (n_q == 6'd1) begin
						st_q <= D_DONE;
					end
				end
				default: st_q <= D_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			D_IDLE: begin
				cnt_sh_q <= CPW'(count);
				acc_q    <= '0;
				d_q      <= divisor;
				wide_q   <= ctl.wide;
				mc_q     <= MC_W'(NCH);
			end
			D_MUL: begin
				acc_q    <= (acc_q << 32) + PW'(prod);
				cnt_sh_q <= cnt_sh_q << 32;
				mc_q     <= mc_q - 1'b1;
			end
			D_CHK: begin
				if (over) begin
					sh_q <= wide_q ? {BPS_W{1'b1}} : BPS_W'({FPS_W{1'b1}});
				end else begin
					rem_q <= hi[62:0];
					sh_q  <= wide_q ? acc_q[BPS_W-1:0]
						: {acc_q[FPS_W-1:0], {(BPS_W - FPS_W){1'b0}}};
					n_q   <= wide_q ? 6'(BPS_W) : 6'(FPS_W);
				end
			end
			D_DIV: begin
				rem_q <= ge ? diff[62:0] : trial[62:0];
				sh_q  <= {sh_q[BPS_W-2:0], ge};
				n_q   <= n_q - 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign done = (st_q == D_DONE);
	assign quot = sh_q;

endmodule

`default_nettype wire

[rtl/wtm_back.sv]
// wtm_back: executes queued commands, keeps window state, builds results
// depends on wtm_pkg and wtm_div
`default_nettype none

module wtm_back
	import wtm_pkg::*;
#(
	parameter int BYTE_COUNTER_BITS  = 48,
	parameter int FRAME_COUNTER_BITS = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_valid,
	input  wire logic [WIN_MS_W-1:0] cfg_data,
	input  wire q_stat_t             q_stat,
	input  wire in_item_t            q_data,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output out_item_t                out_data
);

	localparam int BW = BYTE_COUNTER_BITS;
	localparam int FW = FRAME_COUNTER_BITS;
	localparam int CW = (BW > FW) ? BW : FW;

	localparam logic [2:0] B_IDLE = 3'd0;
	localparam logic [2:0] B_EVAL = 3'd1;
	localparam logic [2:0] B_STB  = 3'd2;
	localparam logic [2:0] B_WTB  = 3'd3;
	localparam logic [2:0] B_STF  = 3'd4;
	localparam logic [2:0] B_WTF  = 3'd5;
	localparam logic [2:0] B_OUT  = 3'd6;

	logic [2:0]          state_q;
	logic [WIN_NS_W-1:0] win_ns_q;
	logic [BW-1:0]       wb_q;
	logic [FW-1:0]       wf_q;
	logic [NOW_W-1:0]    start_q;
	logic [BW-1:0]       lb_q;
	logic [FW-1:0]       lf_q;
	logic [63:0]         lel_q;
	logic                have_last_q;
	logic [NOW_W-1:0]    now_q;
	logic [63:0]         el_q;
	logic [BW-1:0]       srcb_q;
	logic [FW-1:0]       srcf_q;
	logic [63:0]         srcel_q;
	logic                from_last_q;
	logic [BPS_W-1:0]    bps_q;
	logic [FPS_W-1:0]    fps_q;
	logic                out_valid_q;
	out_item_t           out_data_q;

	logic [WIN_MS_W-1:0] cfg_ms;
	logic [BW:0]         byte_sum;
	logic                rot;
	logic                use_last;
	logic [63:0]         sel_el;
	logic                load_out;
	div_ctl_t            div_ctl;
	logic [CW-1:0]       div_count;
	logic                div_done;
	logic [BPS_W-1:0]    div_quot;

	always_comb begin
		cfg_ms   = (cfg_data == '0) ? WIN_MS_W'(1) : cfg_data;
		byte_sum = {1'b0, wb_q} + (BW + 1)'(q_data.byte_count_in);
		rot      = $signed(el_q) >= $signed(64'(win_ns_q));
		use_last = rot || (($signed(el_q) < $signed(64'(win_ns_q >> 1))) && have_last_q);
		if (use_last && !rot) begin
			sel_el = lel_q;
		end else begin
			sel_el = el_q;
		end
		pop      = (state_q == B_IDLE) && !q_stat.empty;
		load_out = (state_q == B_OUT) && (!out_valid_q || out_ready);
		div_ctl.start = (state_q == B_STB) || (state_q == B_STF);
		div_ctl.wide  = (state_q == B_STB);
		div_count     = (state_q == B_STB) ? CW'(srcb_q) : CW'(srcf_q);
	end

	wtm_div #(
		.CNT_BITS(CW)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.count  (div_count),
		.divisor(srcel_q[62:0]),
		.done   (div_done),
		.quot   (div_quot)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			win_ns_q    <= WIN_RESET_NS;
			wb_q        <= '0;
			wf_q        <= '0;
			start_q     <= '0;
			lb_q        <= '0;
			lf_q        <= '0;
			lel_q       <= '0;
			have_last_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				win_ns_q <= WIN_NS_W'(cfg_ms) * WIN_NS_W'(NS_PER_MS);
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: begin
					if (pop) begin
						case (q_data.func)
							FUNC_RECORD: begin
								wb_q <= byte_sum[BW] ? {BW{1'b1}} : byte_sum[BW-1:0];
								if (!(&wf_q)) begin
									wf_q <= wf_q + 1'b1;
								end
							end
							FUNC_CLEAR: begin
								wb_q        <= '0;
								wf_q        <= '0;
								start_q     <= q_data.now_ns;
								lb_q        <= '0;
								lf_q        <= '0;
								lel_q       <= '0;
								have_last_q <= 1'b0;
							end
							FUNC_QUERY: state_q <= B_EVAL;
							default: begin
							end
						endcase
					end
				end
				B_EVAL: begin
					if (rot) begin
						lb_q        <= wb_q;
						lf_q        <= wf_q;
						lel_q       <= el_q;
						have_last_q <= 1'b1;
						wb_q        <= '0;
						wf_q        <= '0;
						start_q     <= now_q;
					end
					if ($signed(sel_el) <= 64'sd0) begin
						state_q <= B_OUT;
					end else begin
						state_q <= B_STB;
					end
				end
				B_STB: state_q <= B_WTB;
				B_WTB: begin
					if (div_done) begin
						state_q <= B_STF;
					end
				end
				B_STF: state_q <= B_WTF;
				B_WTF: begin
					if (div_done) begin
						state_q <= B_OUT;
					end
				end
				B_OUT: begin
					if (load_out) begin
						state_q <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			now_q <= q_data.now_ns;
			el_q  <= {1'b0, q_data.now_ns} - {1'b0, start_q};
		end
		if (state_q == B_EVAL) begin
			from_last_q <= use_last;
			srcel_q     <= sel_el;
			if (use_last && !rot) begin
				srcb_q <= lb_q;
				srcf_q <= lf_q;
			end else begin
				srcb_q <= wb_q;
				srcf_q <= wf_q;
			end
			bps_q <= '0;
			fps_q <= '0;
		end
		if ((state_q == B_WTB) && div_done) begin
			bps_q <= div_quot;
		end
		if ((state_q == B_WTF) && div_done) begin
			fps_q <= div_quot[FPS_W-1:0];
		end
		if (load_out) begin
			out_data_q.bytes_per_sec    <= bps_q;
			out_data_q.frames_per_sec   <= fps_q;
			out_data_q.from_last_window <= from_last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

[rtl/windowed_throughput_meter_top.sv]
// windowed_throughput_meter_top: top level of the windowed throughput meter
// depends on wtm_pkg, wtm_front, wtm_queue, wtm_back
//
// in channel (in_valid/in_ready/in_data) takes record, query and clear words;
// unused function codes are accepted and dropped. out channel carries one
// result word per query. cfg channel writes window_ms; cfg_ready is always
// high and writes belong to idle periods.
// words pass through a four-entry queue; while no query runs, the back end
// retires one record or clear word per cycle, so records sustain one word a
// cycle (an accepted record passes the queue entry register, then updates
// the window counters). a query with a positive elapsed time runs the shared
// scaled divider twice, once for the byte rate and once for the frame rate;
// each run multiplies over the 32-bit chunks of the wider counter, then forms
// 40 or 32 quotient bits unless it saturates; a query whose elapsed time is
// zero or less skips the divider. records queue up behind a running query.
// reset clears the counters, window start and last-window state, sets the
// window to 1000 ms and empties the queue. a stalled receiver holds the
// result in the output register; records keep running, and the next query
// waits for the register to free.
`default_nettype none

module windowed_throughput_meter_top
	import wtm_pkg::*;
#(
	parameter int BYTE_COUNTER_BITS  = 48,
	parameter int FRAME_COUNTER_BITS = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire in_item_t            in_data,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output out_item_t                out_data,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [WIN_MS_W-1:0] cfg_data
);

	q_stat_t  q_stat;
	logic     push;
	in_item_t push_data;
	logic     pop;
	in_item_t pop_data;

	assign cfg_ready = 1'b1;

	wtm_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_stat   (q_stat),
		.push     (push),
		.push_data(push_data)
	);

	wtm_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.pop      (pop),
		.pop_data (pop_data),
		.q_stat   (q_stat)
	);

	wtm_back #(
		.BYTE_COUNTER_BITS (BYTE_COUNTER_BITS),
		.FRAME_COUNTER_BITS(FRAME_COUNTER_BITS)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.q_stat   (q_stat),
		.q_data   (pop_data),
		.pop      (pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

endmodule

`default_nettype wire

[rtl/wtm_checker.sv]
// wtm_checker: port-level assertions for the windowed throughput meter
// depends on wtm_pkg; bound to windowed_throughput_meter_top
`default_nettype none

module wtm_checker
	import wtm_pkg::*;
(
	input wire logic      clk,
	input wire logic      arst_n,
	input wire logic      in_ready,
	input wire logic      out_valid,
	input wire logic      out_ready,
	input wire out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result word changed while stalled");

	a_reset_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> !out_valid)
		else $error("result word valid right after reset");

	a_reset_ready: assert property (@(posedge clk) disable iff (!arst_n)
		$past(!arst_n) |-> in_ready)
		else $error("input not ready right after reset");

	a_no_burst: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready) ##1 (out_valid && out_ready) |=> !out_valid)
		else $error("three result words in consecutive cycles");

endmodule

bind windowed_throughput_meter_top wtm_checker u_wtm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_data (out_data)
);

`default_nettype wire
